// ----- rtl/ssmd_pkg.sv -----
// Shared types, constants and the segment table of the seven-segment scan driver.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssmd_pkg;

   // Field widths
   localparam int VALUE_W    = 16;
   localparam int ACTION_W   = 2;
   localparam int SEG_W      = 8;
   localparam int EN_W       = 4;
   localparam int NIBBLE_W   = 4;
   localparam int BCD_DIGITS = 5;
   localparam int BCD_W      = BCD_DIGITS * NIBBLE_W;

   // Binary-to-BCD pipeline shape: one shift step per value bit
   localparam int DABBLE_STAGES   = 4;
   localparam int STEPS_PER_STAGE = VALUE_W / DABBLE_STAGES;

   // Code for a digit that has not been loaded since reset
   localparam logic [SEG_W-1:0] SEG_ALL_ON = 8'hFF;

   // Request action codes on the input port
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK = 2'd0,
      ACT_DEC  = 2'd1,
      ACT_HEX  = 2'd2
   } action_type;

   // Classified operation carried through the queue and pipeline
   typedef enum logic [1:0] {
      OP_TICK,
      OP_DEC,
      OP_HEX
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   value;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   value;
      logic [BCD_W-1:0]     bcd;
      logic [VALUE_W-1:0]   bin;
   } stage_type;

   // Standard 0-F seven-segment table, bit0 segment a .. bit6 segment g
   function automatic logic [SEG_W-1:0] seg_code(input logic [NIBBLE_W-1:0] nib);
      logic [SEG_W-1:0] code;
      case (nib)
         4'h0: code = 8'h3F;
         4'h1: code = 8'h06;
         4'h2: code = 8'h5B;
         4'h3: code = 8'h4F;
         4'h4: code = 8'h66;
         4'h5: code = 8'h6D;
         4'h6: code = 8'h7D;
         4'h7: code = 8'h07;
         4'h8: code = 8'h7F;
         4'h9: code = 8'h6F;
         4'hA: code = 8'h77;
         4'hB: code = 8'h7C;
         4'hC: code = 8'h39;
         4'hD: code = 8'h5E;
         4'hE: code = 8'h79;
         4'hF: code = 8'h71;
         default: code = SEG_ALL_ON;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ssmd_front.sv -----
// Front end: accepts requests and classifies the action code into an operation.
// Depends on ssmd_pkg; feeds ssmd_queue.
`default_nettype none

module ssmd_front
   import ssmd_pkg::*;
(
   input  wire logic                  req_valid,
   input  wire logic [ACTION_W-1:0]   req_action,
   input  wire logic [VALUE_W-1:0]    req_value,
   output logic                       req_stall,
   input  wire queue_status_type      q_status,
   output logic                       push,
   output item_type                   push_item
);

   logic accept;

   // Stall while the queue has no free entry
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Classify; drop the unused action code without any effect
   always_comb begin
      push           = 1'b0;
      push_item.op   = OP_TICK;
      push_item.value = req_value;
      case (action_type'(req_action))
         ACT_TICK: begin
            push         = accept;
            push_item.op = OP_TICK;
         end
         ACT_DEC: begin
            push         = accept;
            push_item.op = OP_DEC;
         end
         ACT_HEX: begin
            push         = accept;
            push_item.op = OP_HEX;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/ssmd_queue.sv -----
// Two-entry request queue between the front end and the execution pipeline.
// Depends on ssmd_pkg.
`default_nettype none

module ssmd_queue
   import ssmd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire item_type          push_item,
   input  wire logic              pop,
   output queue_status_type       q_status,
   output item_type               head_item
);

   localparam int DEPTH = 2;

   item_type   entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == 2'(DEPTH));
   assign q_status.empty = (count_ff == 2'd0);
   assign head_item      = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold request payloads
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ssmd_back.sv -----
// Execution pipeline: binary-to-BCD stages, digit code store, scan index and
// the response register. Depends on ssmd_pkg; fed by ssmd_queue.
`default_nettype none

module ssmd_back
   import ssmd_pkg::*;
#(
   parameter int NUM_DIGITS = 4
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire queue_status_type  q_status,
   input  wire item_type          head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [EN_W-1:0]        rsp_digit_enable,
   output logic [SEG_W-1:0]       rsp_segments
);

   localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int LAST   = DABBLE_STAGES - 1;

   // Shift-and-add-3 steps for one pipeline stage
   function automatic stage_type dabble_steps(input stage_type s);
      stage_type t;
      t = s;
      for (int n = 0; n < STEPS_PER_STAGE; n++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (t.bcd[NIBBLE_W*d +: NIBBLE_W] >= 4'd5) begin
               t.bcd[NIBBLE_W*d +: NIBBLE_W] = t.bcd[NIBBLE_W*d +: NIBBLE_W] + 4'd3;
            end
         end
         t.bcd = {t.bcd[BCD_W-2:0], t.bin[VALUE_W-1]};
         t.bin = {t.bin[VALUE_W-2:0], 1'b0};
      end
      return t;
   endfunction

   stage_type                 stage_ff [DABBLE_STAGES];
   stage_type                 stage_in [DABBLE_STAGES];
   logic [DABBLE_STAGES-1:0]  valid_ff, valid_in;
   logic [SEG_W-1:0]          codes_ff [NUM_DIGITS];
   logic [SEG_W-1:0]          codes_in [NUM_DIGITS];
   logic [SCAN_W-1:0]         scan_ff, scan_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [EN_W-1:0]           rsp_enable_ff, rsp_enable_in;
   logic [SEG_W-1:0]          rsp_seg_ff, rsp_seg_in;
   logic                      advance;
   logic                      do_tick;
   logic                      do_load;
   logic [BCD_W-1:0]          digit_word;
   stage_type                 head_stage;

   // Move the whole pipeline whenever the response slot frees up
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !q_status.empty;

   // Feed the conversion stages
   always_comb begin
      head_stage.op    = head_item.op;
      head_stage.value = head_item.value;
      head_stage.bcd   = '0;
      head_stage.bin   = head_item.value;
      stage_in[0]      = dabble_steps(head_stage);
      for (int k = 1; k < DABBLE_STAGES; k++) begin
         stage_in[k] = dabble_steps(stage_ff[k-1]);
      end
      valid_in = {valid_ff[DABBLE_STAGES-2:0], !q_status.empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DABBLE_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Retire the last stage: load digit codes or emit a scan response
   assign do_tick = advance && valid_ff[LAST] && (stage_ff[LAST].op == OP_TICK);
   assign do_load = advance && valid_ff[LAST] && (stage_ff[LAST].op != OP_TICK);

   always_comb begin
      int r;
      digit_word = (stage_ff[LAST].op == OP_DEC) ? stage_ff[LAST].bcd :
                   {{(BCD_W-VALUE_W){1'b0}}, stage_ff[LAST].value};
      for (int p = 0; p < NUM_DIGITS; p++) begin
         r = NUM_DIGITS - 1 - p;
         codes_in[p] = do_load ? seg_code(digit_word[NIBBLE_W*r +: NIBBLE_W]) : codes_ff[p];
      end

      scan_in = scan_ff;
      if (do_tick) begin
         scan_in = (scan_ff == SCAN_W'(NUM_DIGITS - 1)) ? '0 : scan_ff + 1'b1;
      end

      for (int b = 0; b < EN_W; b++) begin
         rsp_enable_in[b] = (int'(scan_ff) == b);
      end
      rsp_seg_in   = codes_ff[scan_ff];
      rsp_valid_in = advance ? do_tick : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_DIGITS; p++) begin
            codes_ff[p] <= SEG_ALL_ON;
         end
      end else begin
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int p = 0; p < NUM_DIGITS; p++) begin
            codes_ff[p] <= codes_in[p];
         end
      end
   end

   // Hold the response payload until it is taken
   always_ff @(posedge clock) begin
      if (do_tick) begin
         rsp_enable_ff <= rsp_enable_in;
         rsp_seg_ff    <= rsp_seg_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_enable = rsp_enable_ff;
   assign rsp_segments     = rsp_seg_ff;

endmodule

`default_nettype wire

// ----- rtl/seven_segment_mux_display_unit.sv -----
// Multiplexed seven-segment display driver, top level.
// A scan request passes the queue, the conversion stages and the response register.
// Throughput: one request per cycle, unless a response stall holds the whole pipeline.
// Reset (synchronous): every digit code is 0xFF, scan index 0, queue and pipeline empty.
// Depends on ssmd_pkg, ssmd_front, ssmd_queue and ssmd_back.
`default_nettype none

module seven_segment_mux_display_unit
   import ssmd_pkg::*;
#(
   parameter int NUM_DIGITS = 4
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [VALUE_W-1:0]   req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [EN_W-1:0]           rsp_digit_enable,
   output logic [SEG_W-1:0]          rsp_segments
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         head_item;

   // Accept and classify requests
   ssmd_front u_front (
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_value  (req_value),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   // Decouple front end from execution
   ssmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .q_status   (q_status),
      .head_item  (head_item)
   );

   // Convert, store and scan
   ssmd_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_enable (rsp_digit_enable),
      .rsp_segments     (rsp_segments)
   );

endmodule

`default_nettype wire

// ----- rtl/ssmd_checker.sv -----
// Port-level checks for the seven-segment scan driver, bound to the top level.
// Depends on ssmd_pkg and seven_segment_mux_display_unit.
`default_nettype none

module ssmd_checker
   import ssmd_pkg::*;
#(
   parameter int NUM_DIGITS = 4
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_stall,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [EN_W-1:0]  rsp_digit_enable,
   input  wire logic [SEG_W-1:0] rsp_segments
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_enable) && $stable(rsp_segments))
      else $error("stalled response changed");

   // At most one digit lit
   a_enable_onehot0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_digit_enable))
      else $error("digit enable not one-hot");

   // Every digit has an enable bit when there are at most four digits
   a_enable_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (NUM_DIGITS < 5) |-> rsp_digit_enable != '0)
      else $error("digit enable empty");

   // Reset empties the response slot and leaves the queue with room, so no request stall
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state left after reset");

endmodule

bind seven_segment_mux_display_unit ssmd_checker #(
   .NUM_DIGITS (NUM_DIGITS)
) u_ssmd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_digit_enable (rsp_digit_enable),
   .rsp_segments     (rsp_segments)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the multiplexed seven-segment display driver: directed and random requests
// checked against a scoreboard that predicts every scan response. Depends on ssmd_pkg and
// seven_segment_mux_display_unit.
`timescale 1ns / 100ps

module tb_top;
   import ssmd_pkg::*;

   localparam int DIGITS        = 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 200;
   localparam int REPORT_MAX    = 10;

   // Action code the block leaves unused
   localparam logic [ACTION_W-1:0] ACTION_SPARE = 2'd3;

   // Segment patterns 0..F, digit n at bits 8n+7..8n
   localparam logic [16*SEG_W-1:0] GLYPHS = {
      8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
      8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   typedef struct {
      logic [EN_W-1:0]  enable;
      logic [SEG_W-1:0] segs;
   } scan_frame_type;

   // Tracks the digit codes and scan position, and holds the scan frames still due
   class display_tracker;
      logic [SEG_W-1:0] codes_shown [DIGITS];
      int               scan_pos;
      scan_frame_type   frames_due [$];
      int               errors;

      function new();
         for (int k = 0; k < DIGITS; k++) codes_shown[k] = SEG_ALL_ON;
         scan_pos = 0;
         errors   = 0;
      endfunction

      // Convert a value into digit codes, least significant place at the right
      function void store_number(logic [VALUE_W-1:0] value, int unsigned base);
         int unsigned rest;
         rest = 32'(value);
         for (int pos = DIGITS - 1; pos >= 0; pos--) begin
            codes_shown[pos] = GLYPHS[(rest % base) * SEG_W +: SEG_W];
            rest = rest / base;
         end
      endfunction

      function void take_request(logic [ACTION_W-1:0] action, logic [VALUE_W-1:0] value);
         scan_frame_type frame;
         case (action)
            ACT_TICK: begin
               frame.enable = '0;
               if (scan_pos < EN_W) frame.enable[scan_pos] = 1'b1;
               frame.segs = codes_shown[scan_pos];
               frames_due.push_back(frame);
               scan_pos = (scan_pos + 1) % DIGITS;
            end
            ACT_DEC: store_number(value, 10);
            ACT_HEX: store_number(value, 16);
            default: ;
         endcase
      endfunction

      function void check_scan(logic [EN_W-1:0] enable, logic [SEG_W-1:0] segs);
         scan_frame_type want;
         if (frames_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected response: enable %h segments %h", enable, segs);
            return;
         end
         want = frames_due.pop_front();
         if (enable !== want.enable || segs !== want.segs) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("mismatch: enable exp %h got %h, segments exp %h got %h",
                        want.enable, enable, want.segs, segs);
         end
      endfunction

      function int pending();
         return frames_due.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [EN_W-1:0]     rsp_digit_enable;
   logic [SEG_W-1:0]    rsp_segments;

   display_tracker tracker;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             quiet_cycles;

   seven_segment_mux_display_unit #(.NUM_DIGITS(DIGITS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_enable (rsp_digit_enable),
      .rsp_segments     (rsp_segments)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Stall the response channel at random
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Observe both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) tracker.check_scan(rsp_digit_enable, rsp_segments);
         if (req_valid && !req_stall) tracker.take_request(req_action, req_value);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Abort when nothing moves for too long
   initial begin
      quiet_cycles = 0;
      @(posedge clock);
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   // Offer one request, idling first at random; return at the accepting edge
   task automatic send_request(logic [ACTION_W-1:0] action, logic [VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_value  <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every scan response has come
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic scan_all();
      for (int k = 0; k < DIGITS; k++) send_request(ACT_TICK, VALUE_W'($urandom));
   endtask

   initial begin
      int                  phase;
      int                  sent;
      int                  pick;
      logic [ACTION_W-1:0] act;
      logic [VALUE_W-1:0]  val;

      tracker       = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_TICK;
      req_value     = '0;
      send_idle_pct = 9;
      recv_idle_pct = 62;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset pattern, spare action, decimal and hex extremes
      scan_all();
      send_request(ACTION_SPARE, 16'hFFFF);
      send_request(ACT_TICK, 16'h0000);
      send_request(ACT_DEC, 16'd0);
      scan_all();
      send_request(ACT_DEC, 16'hFFFF);
      scan_all();
      send_request(ACT_DEC, 16'd10000);
      send_request(ACT_TICK, 16'hFFFF);
      send_request(ACT_HEX, 16'hFFFF);
      scan_all();
      send_request(ACT_HEX, 16'h0000);
      send_request(ACT_TICK, 16'h5A5A);
      wait_drained();

      // Random: three idling phases, draining between them
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 9 : 0;
         sent = 0;
         while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) act = ACT_TICK;
            else if (pick < 70) act = ACT_DEC;
            else if (pick < 95) act = ACT_HEX;
            else act = ACTION_SPARE;
            pick = $urandom_range(0, 9);
            if (pick == 0) val = 16'h0000;
            else if (pick == 1) val = 16'hFFFF;
            else if (pick == 2) val = VALUE_W'($urandom_range(0, 9999));
            else val = VALUE_W'($urandom);
            send_request(act, val);
            if (act != ACTION_SPARE) sent++;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ssmd_pkg.sv
rtl/ssmd_front.sv
rtl/ssmd_queue.sv
rtl/ssmd_back.sv
rtl/seven_segment_mux_display_unit.sv
rtl/ssmd_checker.sv
tb/tb_top.sv
